// ===== src/ss2w_pkg.sv =====
// ----------------------------------------------------------------------------
// ss2w_pkg
// Shared beat types and codes for the seven-segment two-wire sender.
// ----------------------------------------------------------------------------
package ss2w_pkg;

    // input beat, one bit-time tick
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] brightness;
        logic [7:0] digit0_segments;
        logic [7:0] digit1_segments;
        logic [7:0] digit2_segments;
        logic [7:0] digit3_segments;
    } t_in_beat;

    // result beat, pin levels and status of one tick
    typedef struct packed {
        logic clock_level;
        logic data_level;
        logic data_driven;
        logic busy_res;
        logic rejected;
        logic done_res;
    } t_out_beat;

    // input mode codes
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_BRIGHT = 2'd1;
    localparam logic [1:0] MODE_SEG    = 2'd2;

    // classified request kind
    typedef enum logic [1:0] {
        KIND_TICK       = 2'd0,
        KIND_BRIGHT     = 2'd1,
        KIND_BRIGHT_BAD = 2'd2,
        KIND_SEG        = 2'd3
    } t_kind;

    // number of segment fields on an input beat
    localparam int DIGIT_FIELDS = 4;

    // classified beat between front and back
    typedef struct packed {
        t_kind      kind;
        logic [2:0] level;
        logic [DIGIT_FIELDS-1:0][7:0] digits;
    } t_cmd_beat;

    // running command codes
    localparam logic [1:0] CMD_IDLE   = 2'd0;
    localparam logic [1:0] CMD_BRIGHT = 2'd1;
    localparam logic [1:0] CMD_SEG    = 2'd2;

    // frame bytes
    localparam logic [7:0] BYTE_DATA_CMD   = 8'h40;
    localparam logic [7:0] BYTE_ADDR_CMD   = 8'hC0;
    localparam logic [7:0] BYTE_BRIGHT_CMD = 8'h88;

    // queue depth on each side of the sequencer
    localparam int QUEUE_DEPTH = 2;

endpackage

// ===== src/ss2w_queue.sv =====
// ----------------------------------------------------------------------------
// ss2w_queue
// Small register queue that decouples two sides of the sender.
// ----------------------------------------------------------------------------
module ss2w_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && !o_empty;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== src/ss2w_front.sv =====
// ----------------------------------------------------------------------------
// ss2w_front
// Classifies each incoming tick into the request kind the sequencer acts on.
// ----------------------------------------------------------------------------
module ss2w_front #(
    parameter int BRIGHTNESS_LIMIT = 7
) (
    input  ss2w_pkg::t_in_beat  i_beat,
    output ss2w_pkg::t_cmd_beat o_cmd
);

    // decode mode and check the level
    always_comb begin
        o_cmd.level  = i_beat.brightness[2:0];
        o_cmd.digits = {i_beat.digit3_segments, i_beat.digit2_segments,
                        i_beat.digit1_segments, i_beat.digit0_segments};
        case (i_beat.mode)
            ss2w_pkg::MODE_BRIGHT: begin
                if (i_beat.brightness > 8'(BRIGHTNESS_LIMIT)) begin
                    o_cmd.kind = ss2w_pkg::KIND_BRIGHT_BAD;
                end else begin
                    o_cmd.kind = ss2w_pkg::KIND_BRIGHT;
                end
            end
            ss2w_pkg::MODE_SEG: begin
                o_cmd.kind = ss2w_pkg::KIND_SEG;
            end
            default: begin
                o_cmd.kind = ss2w_pkg::KIND_TICK;
            end
        endcase
    end

endmodule

// ===== src/ss2w_back.sv =====
// ----------------------------------------------------------------------------
// ss2w_back
// Frame sequencer: one step per classified tick, producing pins and status.
// ----------------------------------------------------------------------------
module ss2w_back #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  ss2w_pkg::t_cmd_beat i_cmd,
    output ss2w_pkg::t_out_beat o_beat
);

    typedef enum logic [10:0] {
        PH_IDLE   = 11'b000_0000_0001,
        PH_START0 = 11'b000_0000_0010,
        PH_START1 = 11'b000_0000_0100,
        PH_BITLO  = 11'b000_0000_1000,
        PH_BITHI  = 11'b000_0001_0000,
        PH_ACKLO  = 11'b000_0010_0000,
        PH_ACKHI  = 11'b000_0100_0000,
        PH_STOP0  = 11'b000_1000_0000,
        PH_STOP1  = 11'b001_0000_0000,
        PH_STOP2  = 11'b010_0000_0000,
        PH_STOP3  = 11'b100_0000_0000
    } t_phase;

    t_phase     r_phase, n_phase, v_phase;
    logic [3:0] r_bitpos, n_bitpos;
    logic [2:0] r_bytepos, n_bytepos;
    logic       r_frame, n_frame;
    logic [7:0] r_shift, n_shift;
    logic [1:0] r_cmd, n_cmd;
    logic       r_clk, n_clk;
    logic       r_dat, n_dat;
    logic [7:0] r_digit [ss2w_pkg::DIGIT_FIELDS];
    logic       w_digit_we;
    logic       w_drv, w_busy, w_rej, w_done;
    logic [3:0] w_frame_bytes;
    logic [2:0] w_digit_idx;

    // bytes in the current frame
    assign w_frame_bytes = (r_cmd == ss2w_pkg::CMD_SEG && r_frame)
                           ? 4'(1 + DIGIT_COUNT) : 4'd1;

    // step logic
    always_comb begin
        n_phase     = r_phase;
        n_bitpos    = r_bitpos;
        n_bytepos   = r_bytepos;
        n_frame     = r_frame;
        n_shift     = r_shift;
        n_cmd       = r_cmd;
        n_clk       = r_clk;
        n_dat       = r_dat;
        v_phase     = r_phase;
        w_digit_we  = 1'b0;
        w_drv       = 1'b1;
        w_busy      = 1'b0;
        w_rej       = 1'b0;
        w_done      = 1'b0;
        w_digit_idx = 3'(r_bytepos);

        // command start or refusal
        if (r_phase == PH_IDLE) begin
            case (i_cmd.kind)
                ss2w_pkg::KIND_BRIGHT: begin
                    n_cmd     = ss2w_pkg::CMD_BRIGHT;
                    n_shift   = ss2w_pkg::BYTE_BRIGHT_CMD | {5'd0, i_cmd.level};
                    n_frame   = 1'b0;
                    n_bytepos = '0;
                    n_bitpos  = '0;
                    v_phase   = PH_START0;
                end
                ss2w_pkg::KIND_BRIGHT_BAD: begin
                    w_rej = 1'b1;
                end
                ss2w_pkg::KIND_SEG: begin
                    w_digit_we = 1'b1;
                    n_cmd      = ss2w_pkg::CMD_SEG;
                    n_shift    = ss2w_pkg::BYTE_DATA_CMD;
                    n_frame    = 1'b0;
                    n_bytepos  = '0;
                    n_bitpos   = '0;
                    v_phase    = PH_START0;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.kind != ss2w_pkg::KIND_TICK) begin
            w_rej = 1'b1;
        end

        // phase step
        case (v_phase)
            PH_START0: begin
                w_busy  = 1'b1;
                n_clk   = 1'b1;
                n_dat   = 1'b1;
                n_phase = PH_START1;
            end
            PH_START1: begin
                w_busy  = 1'b1;
                n_clk   = 1'b1;
                n_dat   = 1'b0;
                n_phase = PH_BITLO;
            end
            PH_BITLO: begin
                w_busy  = 1'b1;
                n_clk   = 1'b0;
                n_dat   = r_shift[0];
                n_phase = PH_BITHI;
            end
            PH_BITHI: begin
                w_busy   = 1'b1;
                n_clk    = 1'b1;
                n_dat    = r_shift[0];
                n_shift  = r_shift >> 1;
                n_bitpos = r_bitpos + 4'd1;
                n_phase  = (n_bitpos >= 4'd8) ? PH_ACKLO : PH_BITLO;
            end
            PH_ACKLO: begin
                w_busy  = 1'b1;
                w_drv   = 1'b0;
                n_clk   = 1'b0;
                n_phase = PH_ACKHI;
            end
            PH_ACKHI: begin
                w_busy    = 1'b1;
                w_drv     = 1'b0;
                n_clk     = 1'b1;
                n_bytepos = r_bytepos + 3'd1;
                n_bitpos  = '0;
                // digit slot is one below the byte position
                w_digit_idx = r_bytepos;
                if ({1'b0, n_bytepos} < w_frame_bytes) begin
                    if (r_cmd == ss2w_pkg::CMD_SEG && r_frame) begin
                        if (w_digit_idx < 3'(ss2w_pkg::DIGIT_FIELDS)) begin
                            n_shift = r_digit[w_digit_idx[1:0]];
                        end else begin
                            n_shift = 8'h00;
                        end
                    end else begin
                        n_shift = ss2w_pkg::BYTE_DATA_CMD;
                    end
                    n_phase = PH_BITLO;
                end else begin
                    n_phase = PH_STOP0;
                end
            end
            PH_STOP0: begin
                w_busy  = 1'b1;
                n_clk   = 1'b0;
                n_phase = PH_STOP1;
            end
            PH_STOP1: begin
                w_busy  = 1'b1;
                n_clk   = 1'b0;
                n_dat   = 1'b0;
                n_phase = PH_STOP2;
            end
            PH_STOP2: begin
                w_busy  = 1'b1;
                n_clk   = 1'b1;
                n_dat   = 1'b0;
                n_phase = PH_STOP3;
            end
            PH_STOP3: begin
                w_busy = 1'b1;
                n_clk  = 1'b1;
                n_dat  = 1'b1;
                if (r_cmd == ss2w_pkg::CMD_SEG && !r_frame) begin
                    // second frame: address byte then digits
                    n_frame   = 1'b1;
                    n_bytepos = '0;
                    n_bitpos  = '0;
                    n_shift   = ss2w_pkg::BYTE_ADDR_CMD;
                    n_phase   = PH_START0;
                end else begin
                    w_done    = 1'b1;
                    n_cmd     = ss2w_pkg::CMD_IDLE;
                    n_frame   = 1'b0;
                    n_bytepos = '0;
                    n_phase   = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // result of this tick
    always_comb begin
        o_beat.clock_level = n_clk;
        o_beat.data_level  = w_drv ? n_dat : 1'b0;
        o_beat.data_driven = w_drv;
        o_beat.busy_res    = w_busy;
        o_beat.rejected    = w_rej;
        o_beat.done_res    = w_done;
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bitpos  <= '0;
            r_bytepos <= '0;
            r_frame   <= 1'b0;
            r_shift   <= '0;
            r_cmd     <= ss2w_pkg::CMD_IDLE;
            r_clk     <= 1'b1;
            r_dat     <= 1'b1;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_bitpos  <= n_bitpos;
            r_bytepos <= n_bytepos;
            r_frame   <= n_frame;
            r_shift   <= n_shift;
            r_cmd     <= n_cmd;
            r_clk     <= n_clk;
            r_dat     <= n_dat;
        end
    end

    // digit store, loaded when a segment write starts
    always_ff @(posedge i_clk) begin
        if (i_fire && w_digit_we) begin
            for (int i = 0; i < ss2w_pkg::DIGIT_FIELDS; i++) begin
                r_digit[i] <= i_cmd.digits[i];
            end
        end
    end

endmodule

// ===== src/seven_segment_two_wire_sender.sv =====
// ----------------------------------------------------------------------------
// seven_segment_two_wire_sender
// Two-wire serial sender for a seven-segment LED driver, one tick per beat.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------
//   ticks    | in        | push / full          | i_in_beat  (t_in_beat)
//   results  | out       | pop / empty          | o_out_beat (t_out_beat)
//
// One beat is taken every cycle while full is low, and one result beat is produced per tick.
// A result beat reaches the outputs through both queues: the tick is written into
// the classified-tick queue, the frame sequencer steps on it in the cycle it leaves
// that queue once the result queue has room, and its result is written into the result queue.
// Reset clears both queues and the sequencer; the digit store holds no reset.
// When results are not popped the result queue fills, the sequencer stops,
// and full rises once the two-entry tick queue is also full.
// ----------------------------------------------------------------------------
module seven_segment_two_wire_sender #(
    parameter int BRIGHTNESS_LIMIT = 7,
    parameter int DIGIT_COUNT      = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  ss2w_pkg::t_in_beat  i_in_beat,
    output logic                empty,
    input  logic                pop,
    output ss2w_pkg::t_out_beat o_out_beat
);

    localparam int CMD_W = $bits(ss2w_pkg::t_cmd_beat);
    localparam int OUT_W = $bits(ss2w_pkg::t_out_beat);

    ss2w_pkg::t_cmd_beat w_cmd_in;
    ss2w_pkg::t_cmd_beat w_cmd_out;
    ss2w_pkg::t_out_beat w_res;
    logic [CMD_W-1:0]    w_cmd_bits;
    logic [OUT_W-1:0]    w_out_bits;
    logic                w_cmd_empty;
    logic                w_res_full;
    logic                w_fire;

    // front: classify each tick
    ss2w_front #(
        .BRIGHTNESS_LIMIT(BRIGHTNESS_LIMIT)
    ) u_front (
        .i_beat(i_in_beat),
        .o_cmd (w_cmd_in)
    );

    // queue between front and sequencer
    ss2w_queue #(
        .WIDTH(CMD_W),
        .DEPTH(ss2w_pkg::QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (w_cmd_in),
        .o_full (full),
        .i_pop  (w_fire),
        .o_empty(w_cmd_empty),
        .o_data (w_cmd_bits)
    );

    assign w_cmd_out = w_cmd_bits;
    assign w_fire    = !w_cmd_empty && !w_res_full;

    // back: frame sequencer
    ss2w_back #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (w_fire),
        .i_cmd  (w_cmd_out),
        .o_beat (w_res)
    );

    // result queue
    ss2w_queue #(
        .WIDTH(OUT_W),
        .DEPTH(ss2w_pkg::QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_fire),
        .i_data (w_res),
        .o_full (w_res_full),
        .i_pop  (pop),
        .o_empty(empty),
        .o_data (w_out_bits)
    );

    assign o_out_beat = w_out_bits;

endmodule
